// ----- hdl/lav_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants for the look-at view matrix core: default word format and
// the fixed widths of the normalize datapath (square root and divider).
// ----------------------------------------------------------------------------
package lav_pkg;

    // Default fixed-point format, signed Q16.16.
    localparam int W_DEF = 32;
    localparam int F_DEF = 16;

    // The squared length is scaled by a power of four to sit just below 2^126.
    localparam int SQ_BITS    = 126;
    // Bits of the integer square root of a SQ_BITS wide value.
    localparam int ROOT_BITS  = 63;
    // Partial remainder width in the restoring divider.
    localparam int REM_BITS   = 64;
    // Width of the half shift (power of four exponent), at most 63.
    localparam int SHIFT_BITS = 6;

endpackage
`default_nettype wire

// ----- hdl/lav_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_in_if
// Input channel: eye, target and up vectors with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lav_in_if
    import lav_pkg::*;
#(
    parameter int WORD_WIDTH = W_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] eye_x;
    logic signed [WORD_WIDTH-1:0] eye_y;
    logic signed [WORD_WIDTH-1:0] eye_z;
    logic signed [WORD_WIDTH-1:0] target_x;
    logic signed [WORD_WIDTH-1:0] target_y;
    logic signed [WORD_WIDTH-1:0] target_z;
    logic signed [WORD_WIDTH-1:0] up_x;
    logic signed [WORD_WIDTH-1:0] up_y;
    logic signed [WORD_WIDTH-1:0] up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        input  ready
    );

    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/lav_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_out_if
// Output channel: the twelve varying view matrix terms with valid/ready.
// ----------------------------------------------------------------------------
interface lav_out_if
    import lav_pkg::*;
#(
    parameter int WORD_WIDTH = W_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] right_x;
    logic signed [WORD_WIDTH-1:0] right_y;
    logic signed [WORD_WIDTH-1:0] right_z;
    logic signed [WORD_WIDTH-1:0] upward_x;
    logic signed [WORD_WIDTH-1:0] upward_y;
    logic signed [WORD_WIDTH-1:0] upward_z;
    logic signed [WORD_WIDTH-1:0] forward_x;
    logic signed [WORD_WIDTH-1:0] forward_y;
    logic signed [WORD_WIDTH-1:0] forward_z;
    logic signed [WORD_WIDTH-1:0] shift_x;
    logic signed [WORD_WIDTH-1:0] shift_y;
    logic signed [WORD_WIDTH-1:0] shift_z;

    modport source (
        output valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               forward_x, forward_y, forward_z, shift_x, shift_y, shift_z,
        input  ready
    );

    modport sink (
        input  valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               forward_x, forward_y, forward_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/lav_norm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined normalize of NUM_VEC three-component vectors: squared length,
// power-of-four scaling, one root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm
    import lav_pkg::*;
#(
    parameter int WORD_WIDTH = W_DEF,
    parameter int FRAC_BITS  = F_DEF,
    parameter int PAY_WIDTH  = 1,
    parameter int NUM_VEC    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [WORD_WIDTH-1:0] i_vec [NUM_VEC][3],
    input  logic [PAY_WIDTH-1:0]         i_pay,
    output logic                         o_valid,
    output logic signed [WORD_WIDTH-1:0] o_vec [NUM_VEC][3],
    output logic [PAY_WIDTH-1:0]         o_pay
);
    localparam int W   = WORD_WIDTH;
    localparam int H   = W / 2;
    localparam int SW  = 2 * W + 2;
    localparam int QB  = FRAC_BITS + 1;
    localparam int CW  = QB + W;
    localparam int LAT = 5 + ROOT_BITS + QB + 1;

    // Half of the even shift that brings the squared length just below 2^126.
    function automatic logic [SHIFT_BITS-1:0] f_half_shift(input logic [SW-1:0] s);
        int len;
        len = 0;
        for (int b = 0; b < SW; b++) begin
            if (s[b]) begin
                len = b + 1;
            end
        end
        return SHIFT_BITS'((SQ_BITS - len) >> 1);
    endfunction

    // Valid and side payload travel alongside the datapath.
    logic [LAT-1:0]       r_vld;
    logic [PAY_WIDTH-1:0] r_pay [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0] <= i_pay;
            for (int s = 1; s < LAT; s++) begin
                r_pay[s] <= r_pay[s-1];
            end
        end
    end

    // Component signs are captured at the first stage and used at the last.
    logic [2:0] r_neg [NUM_VEC][LAT-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int v = 0; v < NUM_VEC; v++) begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[v][0][i] <= i_vec[v][i][W-1];
                end
                for (int s = 1; s < LAT - 1; s++) begin
                    r_neg[v][s] <= r_neg[v][s-1];
                end
            end
        end
    end

    // Squared length: split squares, full squares, three-way sum.
    logic [W-1:0]     r_mag_a [NUM_VEC][3];
    logic [W-1:0]     r_mag_b [NUM_VEC][3];
    logic [W-1:0]     r_mag_c [NUM_VEC][3];
    logic [W-1:0]     r_mag_d [NUM_VEC][3];
    logic [W+H-1:0]   r_pl    [NUM_VEC][3];
    logic [2*W-H-1:0] r_ph    [NUM_VEC][3];
    logic [2*W-1:0]   r_sq    [NUM_VEC][3];
    logic [SW-1:0]    r_s     [NUM_VEC];
    logic [SW-1:0]    r_sd    [NUM_VEC];
    logic [SHIFT_BITS-1:0] r_h [NUM_VEC];
    logic             r_zd    [NUM_VEC];

    always_ff @(posedge i_clk) begin : p_len
        logic [W-1:0] mag;
        if (i_en) begin
            for (int v = 0; v < NUM_VEC; v++) begin
                for (int i = 0; i < 3; i++) begin
                    mag = i_vec[v][i][W-1] ? W'(-i_vec[v][i]) : W'(i_vec[v][i]);
                    r_mag_a[v][i] <= mag;
                    r_pl[v][i]    <= mag * mag[H-1:0];
                    r_ph[v][i]    <= mag * mag[W-1:H];
                    r_mag_b[v][i] <= r_mag_a[v][i];
                    r_sq[v][i]    <= (2*W)'(r_pl[v][i]) + ((2*W)'(r_ph[v][i]) << H);
                    r_mag_c[v][i] <= r_mag_b[v][i];
                    r_mag_d[v][i] <= r_mag_c[v][i];
                end
                r_s[v]  <= SW'(r_sq[v][0]) + SW'(r_sq[v][1]) + SW'(r_sq[v][2]);
                r_sd[v] <= r_s[v];
                r_h[v]  <= f_half_shift(r_s[v]);
                r_zd[v] <= (r_s[v] == '0);
            end
        end
    end

    // Square root, one result bit per stage; index 0 holds the scaled input.
    logic [SQ_BITS-1:0]   r_op  [NUM_VEC][ROOT_BITS+1];
    logic [SQ_BITS-1:0]   r_res [NUM_VEC][ROOT_BITS+1];
    logic [ROOT_BITS-1:0] r_rq  [NUM_VEC][ROOT_BITS+1][3];
    logic                 r_zs  [NUM_VEC][ROOT_BITS+1];

    always_ff @(posedge i_clk) begin : p_sqrt
        logic [SQ_BITS-1:0] one;
        logic [SQ_BITS-1:0] trial;
        if (i_en) begin
            for (int v = 0; v < NUM_VEC; v++) begin
                r_op[v][0]  <= SQ_BITS'(r_sd[v]) << {r_h[v], 1'b0};
                r_res[v][0] <= '0;
                r_zs[v][0]  <= r_zd[v];
                for (int i = 0; i < 3; i++) begin
                    r_rq[v][0][i] <= ROOT_BITS'(SQ_BITS'(r_mag_d[v][i]) << r_h[v]);
                end
                for (int s = 0; s < ROOT_BITS; s++) begin
                    one   = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * s);
                    trial = r_res[v][s] + one;
                    if (r_op[v][s] >= trial) begin
                        r_op[v][s+1]  <= r_op[v][s] - trial;
                        r_res[v][s+1] <= (r_res[v][s] >> 1) + one;
                    end else begin
                        r_op[v][s+1]  <= r_op[v][s];
                        r_res[v][s+1] <= r_res[v][s] >> 1;
                    end
                    r_rq[v][s+1] <= r_rq[v][s];
                    r_zs[v][s+1] <= r_zs[v][s];
                end
            end
        end
    end

    // Restoring divide, one quotient bit per stage, most significant first.
    logic [REM_BITS-1:0]  r_rem [NUM_VEC][QB][3];
    logic [QB-1:0]        r_q   [NUM_VEC][QB][3];
    logic [ROOT_BITS-1:0] r_m   [NUM_VEC][QB];
    logic                 r_zq  [NUM_VEC][QB];

    always_ff @(posedge i_clk) begin : p_div
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] m;
        logic [QB-1:0]        q;
        if (i_en) begin
            for (int v = 0; v < NUM_VEC; v++) begin
                for (int d = 0; d < QB; d++) begin
                    m = (d == 0) ? r_res[v][ROOT_BITS][ROOT_BITS-1:0] : r_m[v][d-1];
                    r_m[v][d]  <= m;
                    r_zq[v][d] <= (d == 0) ? r_zs[v][ROOT_BITS] : r_zq[v][d-1];
                    for (int i = 0; i < 3; i++) begin
                        if (d == 0) begin
                            rem = REM_BITS'(r_rq[v][ROOT_BITS][i]);
                            q   = '0;
                        end else begin
                            rem = r_rem[v][d-1][i] << 1;
                            q   = r_q[v][d-1][i];
                        end
                        if (rem >= REM_BITS'(m)) begin
                            r_rem[v][d][i] <= rem - REM_BITS'(m);
                            r_q[v][d][i]   <= {q[QB-2:0], 1'b1};
                        end else begin
                            r_rem[v][d][i] <= rem;
                            r_q[v][d][i]   <= {q[QB-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    end

    // Apply signs and saturate; a zero-length vector stays zero.
    logic signed [W-1:0] r_out [NUM_VEC][3];

    always_ff @(posedge i_clk) begin : p_out
        logic [CW-1:0] qx;
        logic [CW-1:0] lim;
        logic [W-1:0]  mw;
        logic          neg;
        if (i_en) begin
            for (int v = 0; v < NUM_VEC; v++) begin
                for (int i = 0; i < 3; i++) begin
                    neg = r_neg[v][LAT-2][i];
                    qx  = CW'(r_q[v][QB-1][i]);
                    lim = (CW'(1) << (W - 1)) - CW'(!neg);
                    mw  = (qx > lim) ? W'(lim) : W'(qx);
                    if (r_zq[v][QB-1]) begin
                        r_out[v][i] <= '0;
                    end else begin
                        r_out[v][i] <= neg ? -mw : mw;
                    end
                end
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_pay   = r_pay[LAT-1];
    assign o_vec   = r_out;

endmodule
`default_nettype wire

// ----- hdl/lav_sop.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_sop
// Three sums of three exact signed products, each rounded half away from
// zero by FRAC_BITS and saturated. Four register stages.
// ----------------------------------------------------------------------------
module lav_sop
    import lav_pkg::*;
#(
    parameter int         WORD_WIDTH = W_DEF,
    parameter int         FRAC_BITS  = F_DEF,
    parameter int         PAY_WIDTH  = 1,
    parameter logic [8:0] SUB        = '0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [WORD_WIDTH-1:0] i_a [9],
    input  logic signed [WORD_WIDTH-1:0] i_b [9],
    input  logic [PAY_WIDTH-1:0]         i_pay,
    output logic                         o_valid,
    output logic signed [WORD_WIDTH-1:0] o_res [3],
    output logic [PAY_WIDTH-1:0]         o_pay
);
    localparam int W   = WORD_WIDTH;
    localparam int H   = W / 2;
    localparam int AW  = 2 * W + 2;
    localparam int LAT = 4;

    // Valid and side payload.
    logic [LAT-1:0]       r_vld;
    logic [PAY_WIDTH-1:0] r_pay [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0] <= i_pay;
            for (int s = 1; s < LAT; s++) begin
                r_pay[s] <= r_pay[s-1];
            end
        end
    end

    // Each product is split on the second operand into two narrower ones.
    logic signed [W+H:0]     r_pl  [9];
    logic signed [2*W-H-1:0] r_ph  [9];
    logic signed [AW-1:0]    r_p   [9];
    logic signed [AW-1:0]    r_acc [3];
    logic signed [W-1:0]     r_res [3];

    always_ff @(posedge i_clk) begin : p_mul
        logic signed [AW-1:0] el;
        logic signed [AW-1:0] eh;
        logic signed [AW-1:0] p;
        if (i_en) begin
            for (int t = 0; t < 9; t++) begin
                r_pl[t] <= i_a[t] * $signed({1'b0, i_b[t][H-1:0]});
                r_ph[t] <= i_a[t] * $signed(i_b[t][W-1:H]);
                el = r_pl[t];
                eh = r_ph[t];
                p  = el + (eh <<< H);
                r_p[t] <= SUB[t] ? -p : p;
            end
            for (int r = 0; r < 3; r++) begin
                r_acc[r] <= r_p[3*r] + r_p[3*r+1] + r_p[3*r+2];
            end
        end
    end

    // Round the magnitude half away from zero, then saturate to the word.
    always_ff @(posedge i_clk) begin : p_rnd
        logic          neg;
        logic [AW:0]   mag;
        logic [AW:0]   rnd;
        logic [AW:0]   lim;
        logic [W-1:0]  mw;
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                neg = r_acc[r][AW-1];
                mag = neg ? (AW+1)'(-r_acc[r]) : (AW+1)'(r_acc[r]);
                mag[AW] = 1'b0;
                rnd = (mag + ((AW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                lim = ((AW+1)'(1) << (W - 1)) - (AW+1)'(!neg);
                mw  = (rnd > lim) ? W'(lim) : W'(rnd);
                r_res[r] <= neg ? -mw : mw;
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_pay   = r_pay[LAT-1];
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ----- hdl/look_at_view_matrix_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Builds the x, y and negated z axis rows and the translations of a
// right-handed look-at view matrix from eye, target and up vectors.
//
// Input channel i_in carries one item of eye, target and up, each a signed
// fixed-point word of WORD_WIDTH bits with FRAC_BITS fraction bits. Output
// channel o_out carries one result item of twelve such words per input item.
// Both channels move an item at a clock edge where valid and ready are high.
//
// The core is a single pipeline: one difference stage, a normalize of the
// view direction and of up side by side, a cross product, a normalize of the
// right axis, a second cross product and the three dot products. Each
// normalize has 63 square-root stages and FRAC_BITS + 1 divider stages
// (FRAC_BITS is 16 for the default Q16.16). A new item is taken every cycle
// while the pipeline is not held.
//
// Reset clears all valid bits; items in flight are dropped. When the
// receiver holds ready low with a result waiting, the whole pipeline holds
// and i_in.ready goes low until the result is taken.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core
    import lav_pkg::*;
#(
    parameter int FRAC_BITS  = F_DEF,
    parameter int WORD_WIDTH = W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out
);
    localparam int W  = WORD_WIDTH;
    localparam int XW = W + FRAC_BITS + 2;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    // Cross product pattern: second term of each row is subtracted.
    localparam logic [8:0] SUB_CROSS = 9'b010_010_010;
    localparam logic [8:0] SUB_DOT   = 9'b111_111_111;

    // The pipeline advances unless a result is waiting and not taken.
    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // Stage zero: saturated eye minus target.
    logic signed [W-1:0] w_eye [3];
    logic signed [W-1:0] w_tgt [3];
    logic signed [W-1:0] w_up  [3];
    logic signed [W-1:0] n_d   [3];
    logic signed [W-1:0] r_d   [3];
    logic signed [W-1:0] r_up  [3];
    logic signed [W-1:0] r_eye [3];
    logic                r_v0;

    always_comb begin : p_diff
        logic signed [W:0] diff;
        w_eye[0] = i_in.eye_x;
        w_eye[1] = i_in.eye_y;
        w_eye[2] = i_in.eye_z;
        w_tgt[0] = i_in.target_x;
        w_tgt[1] = i_in.target_y;
        w_tgt[2] = i_in.target_z;
        w_up[0]  = i_in.up_x;
        w_up[1]  = i_in.up_y;
        w_up[2]  = i_in.up_z;
        for (int i = 0; i < 3; i++) begin
            diff = {w_eye[i][W-1], w_eye[i]} - {w_tgt[i][W-1], w_tgt[i]};
            if (diff[W] != diff[W-1]) begin
                n_d[i] = diff[W] ? WMIN : WMAX;
            end else begin
                n_d[i] = diff[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d   <= n_d;
            r_up  <= w_up;
            r_eye <= w_eye;
        end
    end

    // Normalize the view direction and up together.
    logic signed [W-1:0] w_n2_in  [2][3];
    logic signed [W-1:0] w_n2_out [2][3];
    logic [3*W-1:0]      w_n2_pay;
    logic                w_n2_valid;

    assign w_n2_in[0] = r_d;
    assign w_n2_in[1] = r_up;

    lav_norm #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .PAY_WIDTH  (3 * W),
        .NUM_VEC    (2)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v0),
        .i_vec   (w_n2_in),
        .i_pay   ({r_eye[0], r_eye[1], r_eye[2]}),
        .o_valid (w_n2_valid),
        .o_vec   (w_n2_out),
        .o_pay   (w_n2_pay)
    );

    // First cross product: normalized up cross z.
    logic signed [W-1:0] w_c1_a [9];
    logic signed [W-1:0] w_c1_b [9];
    logic signed [W-1:0] w_c    [3];
    logic [6*W-1:0]      w_c1_pay;
    logic                w_c1_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c1_a[3*i]   = w_n2_out[1][(i+1)%3];
            w_c1_b[3*i]   = w_n2_out[0][(i+2)%3];
            w_c1_a[3*i+1] = w_n2_out[1][(i+2)%3];
            w_c1_b[3*i+1] = w_n2_out[0][(i+1)%3];
            w_c1_a[3*i+2] = '0;
            w_c1_b[3*i+2] = '0;
        end
    end

    lav_sop #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .PAY_WIDTH  (6 * W),
        .SUB        (SUB_CROSS)
    ) u_sop_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n2_valid),
        .i_a     (w_c1_a),
        .i_b     (w_c1_b),
        .i_pay   ({w_n2_pay, w_n2_out[0][0], w_n2_out[0][1], w_n2_out[0][2]}),
        .o_valid (w_c1_valid),
        .o_res   (w_c),
        .o_pay   (w_c1_pay)
    );

    // Normalize the right axis.
    logic signed [W-1:0] w_n1_in  [1][3];
    logic signed [W-1:0] w_n1_out [1][3];
    logic [6*W-1:0]      w_n1_pay;
    logic                w_n1_valid;

    assign w_n1_in[0] = w_c;

    lav_norm #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .PAY_WIDTH  (6 * W),
        .NUM_VEC    (1)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c1_valid),
        .i_vec   (w_n1_in),
        .i_pay   (w_c1_pay),
        .o_valid (w_n1_valid),
        .o_vec   (w_n1_out),
        .o_pay   (w_n1_pay)
    );

    // Second cross product: z cross x. Payload is eye, z.
    logic signed [W-1:0] w_z1   [3];
    logic signed [W-1:0] w_c2_a [9];
    logic signed [W-1:0] w_c2_b [9];
    logic signed [W-1:0] w_y    [3];
    logic [9*W-1:0]      w_c2_pay;
    logic                w_c2_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_z1[i] = w_n1_pay[(2-i)*W +: W];
        end
        for (int i = 0; i < 3; i++) begin
            w_c2_a[3*i]   = w_z1[(i+1)%3];
            w_c2_b[3*i]   = w_n1_out[0][(i+2)%3];
            w_c2_a[3*i+1] = w_z1[(i+2)%3];
            w_c2_b[3*i+1] = w_n1_out[0][(i+1)%3];
            w_c2_a[3*i+2] = '0;
            w_c2_b[3*i+2] = '0;
        end
    end

    lav_sop #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .PAY_WIDTH  (9 * W),
        .SUB        (SUB_CROSS)
    ) u_sop_upward (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n1_valid),
        .i_a     (w_c2_a),
        .i_b     (w_c2_b),
        .i_pay   ({w_n1_pay, w_n1_out[0][0], w_n1_out[0][1], w_n1_out[0][2]}),
        .o_valid (w_c2_valid),
        .o_res   (w_y),
        .o_pay   (w_c2_pay)
    );

    // Forward row is the saturated negation of z; then the three dot products.
    // Payload order here is eye, z, x from the top down.
    logic signed [W-1:0] w_eye2 [3];
    logic signed [W-1:0] w_z2   [3];
    logic signed [W-1:0] w_x2   [3];
    logic signed [W-1:0] w_f    [3];
    logic signed [W-1:0] w_d_a  [9];
    logic signed [W-1:0] w_d_b  [9];
    logic signed [W-1:0] w_sh   [3];
    logic [9*W-1:0]      w_d_pay;
    logic                w_d_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_eye2[i] = w_c2_pay[(8-i)*W +: W];
            w_z2[i]   = w_c2_pay[(5-i)*W +: W];
            w_x2[i]   = w_c2_pay[(2-i)*W +: W];
            w_f[i]    = (w_z2[i] == WMIN) ? WMAX : -w_z2[i];
        end
        for (int t = 0; t < 3; t++) begin
            w_d_a[t]   = w_x2[t];
            w_d_a[3+t] = w_y[t];
            w_d_a[6+t] = w_f[t];
            w_d_b[t]   = w_eye2[t];
            w_d_b[3+t] = w_eye2[t];
            w_d_b[6+t] = w_eye2[t];
        end
    end

    lav_sop #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .PAY_WIDTH  (9 * W),
        .SUB        (SUB_DOT)
    ) u_sop_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c2_valid),
        .i_a     (w_d_a),
        .i_b     (w_d_b),
        .i_pay   ({w_x2[0], w_x2[1], w_x2[2], w_y[0], w_y[1], w_y[2],
                   w_f[0], w_f[1], w_f[2]}),
        .o_valid (w_d_valid),
        .o_res   (w_sh),
        .o_pay   (w_d_pay)
    );

    // Result item.
    assign o_out.valid     = w_d_valid;
    assign o_out.right_x   = w_d_pay[8*W +: W];
    assign o_out.right_y   = w_d_pay[7*W +: W];
    assign o_out.right_z   = w_d_pay[6*W +: W];
    assign o_out.upward_x  = w_d_pay[5*W +: W];
    assign o_out.upward_y  = w_d_pay[4*W +: W];
    assign o_out.upward_z  = w_d_pay[3*W +: W];
    assign o_out.forward_x = w_d_pay[2*W +: W];
    assign o_out.forward_y = w_d_pay[1*W +: W];
    assign o_out.forward_z = w_d_pay[0 +: W];
    assign o_out.shift_x   = w_sh[0];
    assign o_out.shift_y   = w_sh[1];
    assign o_out.shift_z   = w_sh[2];

    // Checks on the result rows.
    localparam logic signed [XW-1:0] UNIT = XW'(1) << FRAC_BITS;

    logic w_fwd_zero;
    logic w_right_zero;
    logic w_up_zero;
    logic w_shift_zero;
    logic w_unit_ok;

    assign w_fwd_zero   = (o_out.forward_x == '0) && (o_out.forward_y == '0)
                       && (o_out.forward_z == '0);
    assign w_right_zero = (o_out.right_x == '0) && (o_out.right_y == '0)
                       && (o_out.right_z == '0);
    assign w_up_zero    = (o_out.upward_x == '0) && (o_out.upward_y == '0)
                       && (o_out.upward_z == '0);
    assign w_shift_zero = (o_out.shift_x == '0) && (o_out.shift_y == '0)
                       && (o_out.shift_z == '0);
    assign w_unit_ok    = (o_out.right_x <= UNIT) && (o_out.right_x >= -UNIT)
                       && (o_out.right_y <= UNIT) && (o_out.right_y >= -UNIT)
                       && (o_out.right_z <= UNIT) && (o_out.right_z >= -UNIT)
                       && (o_out.forward_x <= UNIT) && (o_out.forward_x >= -UNIT)
                       && (o_out.forward_y <= UNIT) && (o_out.forward_y >= -UNIT)
                       && (o_out.forward_z <= UNIT) && (o_out.forward_z >= -UNIT);

    // A degenerate view direction zeroes every other row.
    a_zero_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && w_fwd_zero |-> w_right_zero && w_up_zero && w_shift_zero)
        else $error("zero view direction gave nonzero rows");

    // With no right axis the up row must vanish as well.
    a_zero_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && w_right_zero |-> w_up_zero)
        else $error("zero right axis gave nonzero upward row");

    // Normalized rows never exceed one in magnitude.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> w_unit_ok)
        else $error("normalized row component out of range");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
